FILE: rtl/msi_pkg.sv
package msi_pkg;

	localparam int MAX_LAYERS_DEF = 4;
	localparam int MAX_INPUTS_DEF = 1024;
	localparam int MAX_HIDDEN_DEF = 64;

	localparam int CFG_AW = 5;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_BIAS   = 2'd1,
		CMD_FEAT   = 2'd2,
		CMD_EVAL   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_LAYERS = 3'd0,
		REG_INPUTS = 3'd1,
		REG_HID1   = 3'd2,
		REG_HID2   = 3'd3,
		REG_HID3   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [1:0]         layer;
		logic [9:0]         row;
		logic [5:0]         col;
		logic signed [15:0] value;
	} item_t;

	typedef struct packed {
		logic [2:0]  layer_count;
		logic [10:0] input_width;
		logic [6:0]  hid1;
		logic [6:0]  hid2;
		logic [6:0]  hid3;
	} cfg_t;

	typedef logic [16:0] sig_tab_t [17];
	localparam sig_tab_t SIG_TABLE = '{
		17'd32768, 17'd40793, 17'd47911, 17'd53581, 17'd57724, 17'd60565,
		17'd62428, 17'd63615, 17'd64357, 17'd64816, 17'd65097, 17'd65269,
		17'd65374, 17'd65438, 17'd65476, 17'd65500, 17'd65514
	};

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7FFF;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic [16:0] sigmoid_q(input logic signed [15:0] x);
		logic [16:0] a;
		logic [16:0] s;
		logic [3:0]  i;
		logic [6:0]  f;
		logic [16:0] d;
		logic [23:0] p;
		a = x[15] ? 17'(-{x[15], x}) : {1'b0, x};
		i = a[10:7];
		f = a[6:0];
		if (a >= 17'd2048) begin
			s = SIG_TABLE[16];
		end else begin
			d = SIG_TABLE[5'(i) + 5'd1] - SIG_TABLE[i];
			p = 24'(d) * 24'(f);
			s = SIG_TABLE[i] + 17'(p >> 7);
		end
		return x[15] ? 17'(17'h10000 - s) : s;
	endfunction

endpackage

FILE: rtl/msi_front.sv
module msi_front
	import msi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item_in,
	output logic  head_valid,
	output item_t head,
	input  logic  pop
);

	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= item_in;
	end

endmodule

FILE: rtl/msi_engine.sv
module msi_engine
	import msi_pkg::*;
#(
	parameter int MAX_LAYERS = MAX_LAYERS_DEF,
	parameter int MAX_INPUTS = MAX_INPUTS_DEF,
	parameter int MAX_HIDDEN = MAX_HIDDEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  item_t       head,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] win_prob
);

	localparam int NMAX   = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
	localparam int CW     = $clog2(NMAX + 1);
	localparam int AW     = 33 + $clog2(NMAX);
	localparam int LMAX   = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
	localparam int FW_D   = MAX_INPUTS * MAX_HIDDEN;
	localparam int LW_D   = (MAX_LAYERS - 1) * MAX_HIDDEN * MAX_HIDDEN;
	localparam int B_D    = MAX_LAYERS * MAX_HIDDEN;
	localparam int A_D    = 2 * MAX_HIDDEN;
	localparam int FW_AW  = $clog2(FW_D);
	localparam int LW_AW  = $clog2(LW_D);
	localparam int B_AW   = $clog2(B_D);
	localparam int F_AW   = $clog2(MAX_INPUTS);
	localparam int A_AW   = $clog2(A_D);

	typedef enum logic [2:0] {
		S_IDLE, S_MAC, S_SUM, S_SAT, S_SIG, S_SWM, S_WR, S_OUT
	} state_t;

	state_t state_q;

	logic signed [15:0] fw_mem [FW_D];
	logic signed [15:0] lw_mem [LW_D];
	logic signed [15:0] b_mem  [B_D];
	logic signed [15:0] f_mem  [MAX_INPUTS];
	logic signed [15:0] a_mem  [A_D];

	logic signed [15:0] fw_rd, lw_rd, b_rd, f_rd, a_rd;

	logic [1:0]         l_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      cnt_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] sum_q;
	logic signed [15:0] x_q;
	logic [16:0]        sig_q;
	logic signed [33:0] prodw_q;
	logic               v_s1, last_s1, v_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic               rvalid_q;
	logic [15:0]        win_q;

	logic [2:0]    nl;
	logic [CW-1:0] w0;
	logic [CW-1:0] wh [3];
	logic [CW-1:0] n_in, n_out;
	logic          l0, last_layer;
	logic          issue, last_issue;
	logic          do_wr;
	logic          fw_we, lw_we, b_we, f_we, a_we;
	logic [31:0]   fw_wa, lw_wa, b_wa, fw_ra, lw_ra, b_ra, a_ra, a_wa;
	logic [6:0]    hraw [3];

	assign hraw[0] = cfg.hid1;
	assign hraw[1] = cfg.hid2;
	assign hraw[2] = cfg.hid3;

	always_comb begin
		if (cfg.layer_count < 3'd2) nl = 3'd2;
		else if (int'(cfg.layer_count) > LMAX) nl = 3'(LMAX);
		else nl = cfg.layer_count;
		if (cfg.input_width == 11'd0) w0 = CW'(1);
		else if (int'(cfg.input_width) > MAX_INPUTS) w0 = CW'(MAX_INPUTS);
		else w0 = CW'(cfg.input_width);
		for (int h = 0; h < 3; h++) begin
			if (hraw[h] == 7'd0) wh[h] = CW'(1);
			else if (int'(hraw[h]) > MAX_HIDDEN) wh[h] = CW'(MAX_HIDDEN);
			else wh[h] = CW'(hraw[h]);
		end
	end

	assign l0         = (l_q == 2'd0);
	assign last_layer = ({1'b0, l_q} == nl - 3'd1);
	assign n_in       = l0 ? w0 : wh[l_q - 2'd1];
	assign n_out      = last_layer ? CW'(1) : wh[l_q];
	assign issue      = (state_q == S_MAC) && (cnt_q < n_in);
	assign last_issue = (cnt_q == n_in - CW'(1));

	assign pop   = (state_q == S_IDLE) && head_valid;
	assign do_wr = pop && (head.cmd != CMD_EVAL);

	always_comb begin
		fw_we = do_wr && head.cmd == CMD_WEIGHT && head.layer == 2'd0
			&& int'(head.row) < MAX_INPUTS && int'(head.col) < MAX_HIDDEN;
		lw_we = do_wr && head.cmd == CMD_WEIGHT && head.layer != 2'd0
			&& int'(head.layer) < MAX_LAYERS && int'(head.row) < MAX_HIDDEN
			&& int'(head.col) < MAX_HIDDEN;
		b_we  = do_wr && head.cmd == CMD_BIAS && int'(head.layer) < MAX_LAYERS
			&& int'(head.col) < MAX_HIDDEN;
		f_we  = do_wr && head.cmd == CMD_FEAT && int'(head.row) < MAX_INPUTS;
		a_we  = (state_q == S_WR);
		fw_wa = 32'(int'(head.row) * MAX_HIDDEN + int'(head.col));
		lw_wa = 32'(((int'(head.layer) - 1) * MAX_HIDDEN + int'(head.row)) * MAX_HIDDEN
			+ int'(head.col));
		b_wa  = 32'(int'(head.layer) * MAX_HIDDEN + int'(head.col));
		fw_ra = 32'(int'(cnt_q) * MAX_HIDDEN + int'(j_q));
		lw_ra = 32'(((int'(l_q) - 1) * MAX_HIDDEN + int'(cnt_q)) * MAX_HIDDEN + int'(j_q));
		b_ra  = 32'(int'(l_q) * MAX_HIDDEN + int'(j_q));
		a_ra  = 32'(int'(l_q[0] ^ 1'b1) * MAX_HIDDEN + int'(cnt_q));
		a_wa  = 32'(int'(l_q[0]) * MAX_HIDDEN + int'(j_q));
	end

	always_ff @(posedge clk) begin
		if (fw_we) fw_mem[fw_wa[FW_AW-1:0]] <= head.value;
		fw_rd <= fw_mem[fw_ra[FW_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (lw_we) lw_mem[lw_wa[LW_AW-1:0]] <= head.value;
		lw_rd <= lw_mem[lw_ra[LW_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (b_we) b_mem[b_wa[B_AW-1:0]] <= head.value;
		b_rd <= b_mem[b_ra[B_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (f_we) f_mem[head.row[F_AW-1:0]] <= head.value;
		f_rd <= f_mem[cnt_q[F_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (a_we) a_mem[a_wa[A_AW-1:0]] <= sat16(64'(prodw_q >>> 16));
		a_rd <= a_mem[a_ra[A_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= l0 ? f_rd * fw_rd : a_rd * lw_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			l_q      <= 2'd0;
			j_q      <= '0;
			cnt_q    <= '0;
			acc_q    <= '0;
			sum_q    <= '0;
			x_q      <= '0;
			sig_q    <= '0;
			prodw_q  <= '0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			rvalid_q <= 1'b0;
			win_q    <= '0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && last_issue;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (rvalid_q && !result_stall && state_q != S_OUT) rvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop && head.cmd == CMD_EVAL) begin
						l_q     <= 2'd0;
						j_q     <= '0;
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (issue) cnt_q <= cnt_q + CW'(1);
					if (v_s2) acc_q <= acc_q + AW'(prod_s2);
					if (v_s2 && last_s2) state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q   <= l0 ? acc_q + AW'(b_rd) : acc_q + (AW'(b_rd) <<< 8);
					state_q <= S_SAT;
				end
				S_SAT: begin
					x_q     <= l0 ? sat16(64'(sum_q)) : sat16(64'(sum_q >>> 8));
					state_q <= S_SIG;
				end
				S_SIG: begin
					sig_q   <= sigmoid_q(x_q);
					state_q <= last_layer ? S_OUT : S_SWM;
				end
				S_SWM: begin
					prodw_q <= x_q * $signed({1'b0, sig_q});
					state_q <= S_WR;
				end
				S_WR: begin
					cnt_q   <= '0;
					acc_q   <= '0;
					state_q <= S_MAC;
					if (j_q == n_out - CW'(1)) begin
						j_q <= '0;
						l_q <= l_q + 2'd1;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_OUT: begin
					if (!rvalid_q || !result_stall) begin
						rvalid_q <= 1'b1;
						win_q    <= sig_q[16] ? 16'hFFFF : sig_q[15:0];
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = rvalid_q;
	assign win_prob     = win_q;

endmodule

FILE: rtl/mlp_swish_inference.sv
// Dense perceptron evaluator with swish hidden layers and a sigmoid output.
// Input channel (item_valid / item_stall) carries cmd, layer, row, col, value.
// Weight, bias and feature writes give no result; they stream one beat per
// cycle through a two-entry queue while no evaluate is running.
// An evaluate beat gives one win_prob beat on result_valid / result_stall.
// Evaluation runs one multiply-accumulate per cycle from memories with
// registered reads; each neuron then drains the multiply pipeline, adds its
// bias, saturates and takes the sigmoid; a hidden neuron then forms swish
// and writes its activation, the output neuron loads the result register.
// Beats behind an evaluate wait in the queue until it finishes.
// The result waits in an output register while result_stall is high;
// the next evaluate then holds in its last step until the register frees.
// Reset clears control and the registers to layer_count 2, input_width 1024,
// hidden widths 64; memories hold nothing valid until written.
// APB-style configuration port, pready always high, one register every 4 bytes;
// the user writes it only while the block is idle; nothing here enforces that.
module mlp_swish_inference
	import msi_pkg::*;
#(
	parameter int MAX_LAYERS = MAX_LAYERS_DEF,
	parameter int MAX_INPUTS = MAX_INPUTS_DEF,
	parameter int MAX_HIDDEN = MAX_HIDDEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        cmd,
	input  logic [1:0]        layer,
	input  logic [9:0]        row,
	input  logic [5:0]        col,
	input  logic signed [15:0] value,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [15:0]       win_prob,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t     cfg_q;
	item_t    item_in;
	item_t    head;
	logic     head_valid;
	logic     pop;
	reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layer_count <= 3'd2;
			cfg_q.input_width <= 11'd1024;
			cfg_q.hid1        <= 7'd64;
			cfg_q.hid2        <= 7'd64;
			cfg_q.hid3        <= 7'd64;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_LAYERS: cfg_q.layer_count <= pwdata[2:0];
				REG_INPUTS: cfg_q.input_width <= pwdata[10:0];
				REG_HID1:   cfg_q.hid1        <= pwdata[6:0];
				REG_HID2:   cfg_q.hid2        <= pwdata[6:0];
				REG_HID3:   cfg_q.hid3        <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_LAYERS: prdata = 32'(cfg_q.layer_count);
			REG_INPUTS: prdata = 32'(cfg_q.input_width);
			REG_HID1:   prdata = 32'(cfg_q.hid1);
			REG_HID2:   prdata = 32'(cfg_q.hid2);
			REG_HID3:   prdata = 32'(cfg_q.hid3);
			default:    prdata = '0;
		endcase
	end

	assign item_in = '{cmd: cmd_t'(cmd), layer: layer, row: row, col: col, value: value};

	msi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_in    (item_in),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	msi_engine #(
		.MAX_LAYERS (MAX_LAYERS),
		.MAX_INPUTS (MAX_INPUTS),
		.MAX_HIDDEN (MAX_HIDDEN)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.win_prob     (win_prob)
	);

endmodule

FILE: rtl/msi_checker.sv
module msi_checker
	import msi_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic [1:0]        cmd,
	input logic [1:0]        layer,
	input logic [9:0]        row,
	input logic [5:0]        col,
	input logic signed [15:0] value,
	input logic              result_valid,
	input logic              result_stall,
	input logic [15:0]       win_prob,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(win_prob))
		else $error("result beat dropped while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable({cmd, layer, row, col, value}))
		else $error("input beat changed while stalled");

	a_layers: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[4:2] == 3'd0 ##1 paddr[4:2] == 3'd0)
		|-> prdata[2:0] == $past(pwdata[2:0]))
		else $error("layer_count readback mismatch");

	a_inputs: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[4:2] == 3'd1 ##1 paddr[4:2] == 3'd1)
		|-> prdata[10:0] == $past(pwdata[10:0]))
		else $error("input_width readback mismatch");

endmodule

bind mlp_swish_inference msi_checker u_msi_checker (.*);

FILE: dv/tb_mlp_swish_inference.sv
`timescale 1ns / 1ps

module tb_mlp_swish_inference;
	import msi_pkg::*;

	localparam int HID = 64;
	localparam int SIG_Q [17] = '{
		32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
		64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t beat = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	logic [15:0] win_prob;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	mlp_swish_inference dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(beat.cmd), .layer(beat.layer), .row(beat.row), .col(beat.col),
		.value(beat.value),
		.result_valid(result_valid), .result_stall(result_stall), .win_prob(win_prob),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state, updated at each accepted beat
	logic signed [15:0] first_w [65536];
	logic signed [15:0] later_w [12288];
	logic signed [15:0] bias_mem [256];
	logic signed [15:0] feat_mem [1024];
	logic [2:0] layer_cnt = 3'd2;
	logic [10:0] in_width = 11'd1024;
	logic [6:0] hid_width [3] = '{7'd64, 7'd64, 7'd64};

	// entries the stimulus has already loaded
	bit first_ok [65536];
	bit later_ok [12288];
	bit bias_ok [256];
	bit feat_ok [1024];

	item_t pending [$];
	logic [15:0] prob_q [$];
	int pushed = 0;
	int accepted = 0;
	int errors = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold_req = 0;
	int rx_left = 0;
	int eff_w [4];
	int eff_nl;

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sat_q88(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic longint sigmoid_q16(longint x);
		longint a;
		longint s;
		int i;
		a = x < 0 ? -x : x;
		if (a >= 2048) begin
			s = SIG_Q[16];
		end else begin
			i = int'(a >> 7);
			s = SIG_Q[i] + (((SIG_Q[i + 1] - SIG_Q[i]) * (a & 127)) >> 7);
		end
		return x < 0 ? 65536 - s : s;
	endfunction

	function automatic logic signed [15:0] swish_q88(longint x);
		return 16'(sat_q88((x * sigmoid_q16(x)) >>> 16));
	endfunction

	function automatic logic [15:0] win_prob_of_net();
		int nl;
		int w [4];
		int src;
		int dst;
		longint acc;
		longint p;
		logic signed [15:0] act [2][HID];
		nl = clampi(int'(layer_cnt), 2, 4);
		w[0] = clampi(int'(in_width), 1, 1024);
		for (int k = 0; k < 3; k++) w[k + 1] = clampi(int'(hid_width[k]), 1, HID);
		for (int j = 0; j < w[1]; j++) begin
			acc = 0;
			for (int k = 0; k < w[0]; k++)
				acc += longint'(feat_mem[k]) * longint'(first_w[k * HID + j]);
			acc += longint'(bias_mem[j]);
			act[0][j] = swish_q88(sat_q88(acc));
		end
		for (int l = 1; l + 1 < nl; l++) begin
			src = (l - 1) & 1;
			dst = l & 1;
			for (int j = 0; j < w[l + 1]; j++) begin
				acc = 0;
				for (int k = 0; k < w[l]; k++)
					acc += longint'(act[src][k]) *
						longint'(later_w[((l - 1) * HID + k) * HID + j]);
				acc += longint'(bias_mem[l * HID + j]) * 256;
				act[dst][j] = swish_q88(sat_q88(acc >>> 8));
			end
		end
		src = (nl - 2) & 1;
		acc = 0;
		for (int k = 0; k < w[nl - 1]; k++)
			acc += longint'(act[src][k]) * longint'(later_w[((nl - 2) * HID + k) * HID]);
		acc += longint'(bias_mem[(nl - 1) * HID]) * 256;
		p = sigmoid_q16(sat_q88(acc >>> 8));
		return p > 65535 ? 16'hFFFF : 16'(p);
	endfunction

	function automatic void apply_beat(item_t it);
		case (it.cmd)
			CMD_WEIGHT: begin
				if (it.layer == 0) first_w[it.row * HID + it.col] = it.value;
				else if (it.row < HID)
					later_w[((it.layer - 1) * HID + it.row) * HID + it.col] = it.value;
			end
			CMD_BIAS: bias_mem[it.layer * HID + it.col] = it.value;
			CMD_FEAT: feat_mem[it.row] = it.value;
			CMD_EVAL: prob_q = {prob_q, win_prob_of_net()};
			default: ;
		endcase
	endfunction

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				apply_beat(beat);
				accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (pending.size() == 0 || $urandom_range(99) < tx_gap) begin
					item_valid <= 1'b0;
				end else begin
					beat <= pending.pop_front();
					item_valid <= 1'b1;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_left <= rx_hold_req;
			rx_hold_req = 0;
		end else if (rx_left > 0) begin
			rx_left <= rx_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b1;
		end else begin
			if (result_valid && !result_stall) begin
				if (prob_q.size() == 0) begin
					$error("win_prob beat with nothing expected: actual %0d", win_prob);
					errors++;
				end else begin
					if (win_prob !== prob_q[0]) begin
						$error("win_prob: expected %0d, actual %0d", prob_q[0], win_prob);
						errors++;
					end
					void'(prob_q.pop_front());
				end
			end
			result_stall <= (rx_left > 1) || ($urandom_range(99) < rx_gap);
		end
	end

	function automatic logic signed [15:0] rand_value();
		int r;
		r = $urandom_range(99);
		if (r < 10) return r < 5 ? 16'sh7FFF : 16'sh8000;
		if (r < 60) return 16'($urandom_range(1023)) - 16'sd512;
		return 16'($urandom);
	endfunction

	task automatic push_item(cmd_t c, int ly, int rw, int cl, logic signed [15:0] v);
		item_t it;
		it.cmd = c;
		it.layer = 2'(ly);
		it.row = 10'(rw);
		it.col = 6'(cl);
		it.value = v;
		case (c)
			CMD_WEIGHT: begin
				if (it.layer == 0) first_ok[it.row * HID + it.col] = 1'b1;
				else if (it.row < HID)
					later_ok[((it.layer - 1) * HID + it.row) * HID + it.col] = 1'b1;
			end
			CMD_BIAS: bias_ok[it.layer * HID + it.col] = 1'b1;
			CMD_FEAT: feat_ok[it.row] = 1'b1;
			default: ;
		endcase
		pending = {pending, it};
		pushed++;
	endtask

	task automatic drain();
		do @(posedge clk); while (accepted != pushed || prob_q.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(4 * int'(idx));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LAYERS: layer_cnt = v[2:0];
			REG_INPUTS: in_width = v[10:0];
			REG_HID1: hid_width[0] = v[6:0];
			REG_HID2: hid_width[1] = v[6:0];
			REG_HID3: hid_width[2] = v[6:0];
			default: ;
		endcase
	endtask

	task automatic configure(int lc, int iw, int h1, int h2, int h3);
		drain();
		apb_write(REG_LAYERS, 32'(lc));
		apb_write(REG_INPUTS, 32'(iw));
		apb_write(REG_HID1, 32'(h1));
		apb_write(REG_HID2, 32'(h2));
		apb_write(REG_HID3, 32'(h3));
		eff_nl = clampi(lc & 7, 2, 4);
		eff_w[0] = clampi(iw & 'h7FF, 1, 1024);
		eff_w[1] = clampi(h1 & 'h7F, 1, HID);
		eff_w[2] = clampi(h2 & 'h7F, 1, HID);
		eff_w[3] = clampi(h3 & 'h7F, 1, HID);
	endtask

	// load every entry the current shape reads that is still unloaded
	task automatic load_missing();
		int outs;
		for (int k = 0; k < eff_w[0]; k++) begin
			if (!feat_ok[k]) push_item(CMD_FEAT, 0, k, 0, rand_value());
			for (int j = 0; j < eff_w[1]; j++)
				if (!first_ok[k * HID + j]) push_item(CMD_WEIGHT, 0, k, j, rand_value());
		end
		for (int l = 0; l < eff_nl; l++) begin
			outs = (l == eff_nl - 1) ? 1 : eff_w[l + 1];
			for (int j = 0; j < outs; j++)
				if (!bias_ok[l * HID + j]) push_item(CMD_BIAS, l, 0, j, rand_value());
			if (l > 0)
				for (int k = 0; k < eff_w[l]; k++)
					for (int j = 0; j < outs; j++)
						if (!later_ok[((l - 1) * HID + k) * HID + j])
							push_item(CMD_WEIGHT, l, k, j, rand_value());
		end
	endtask

	task automatic random_items(int n, int eval_pct);
		int r;
		int l;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < eval_pct) begin
				push_item(CMD_EVAL, $urandom_range(3), $urandom_range(1023),
					$urandom_range(63), 16'($urandom));
			end else if (r < 85) begin
				l = $urandom_range(eff_nl - 1);
				case ($urandom_range(2))
					0: push_item(CMD_FEAT, $urandom_range(3), $urandom_range(eff_w[0] - 1),
						$urandom_range(63), rand_value());
					1: push_item(CMD_BIAS, l, $urandom_range(1023),
						$urandom_range(l == eff_nl - 1 ? 0 : eff_w[l + 1] - 1), rand_value());
					default: push_item(CMD_WEIGHT, l, $urandom_range(eff_w[l] - 1),
						$urandom_range(l == eff_nl - 1 ? 0 : eff_w[l + 1] - 1), rand_value());
				endcase
			end else begin
				push_item(cmd_t'($urandom_range(2)), $urandom_range(3), $urandom_range(1023),
					$urandom_range(63), 16'($urandom));
			end
		end
	endtask

	task automatic set_idling(int mode);
		tx_gap = mode == 0 ? 32 : (mode == 1 ? 52 : 0);
		rx_gap = mode == 0 ? 52 : (mode == 1 ? 32 : 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(2);
		configure(2, 2, 1, 64, 64);
		push_item(CMD_FEAT, 0, 0, 0, 16'sd0);
		push_item(CMD_FEAT, 0, 1, 0, 16'sd0);
		push_item(CMD_WEIGHT, 0, 0, 0, 16'sd0);
		push_item(CMD_WEIGHT, 0, 1, 0, 16'sd0);
		push_item(CMD_BIAS, 0, 0, 0, 16'sd0);
		push_item(CMD_WEIGHT, 1, 0, 0, 16'sd0);
		push_item(CMD_BIAS, 1, 0, 0, 16'sd0);
		push_item(CMD_EVAL, 0, 0, 0, 16'sd0);
		push_item(CMD_BIAS, 1, 0, 0, 16'sh7FFF);
		push_item(CMD_EVAL, 3, 1023, 63, 16'sh7FFF);
		push_item(CMD_BIAS, 1, 0, 0, 16'sh8000);
		push_item(CMD_EVAL, 0, 0, 0, 16'sh8000);
		push_item(CMD_FEAT, 0, 0, 0, 16'sh7FFF);
		push_item(CMD_WEIGHT, 0, 0, 0, 16'sh7FFF);
		push_item(CMD_WEIGHT, 1, 0, 0, 16'sh7FFF);
		push_item(CMD_BIAS, 1, 0, 0, 16'sd0);
		push_item(CMD_EVAL, 0, 0, 0, 16'sd0);
		push_item(CMD_FEAT, 1, 1, 63, 16'sh8000);
		push_item(CMD_WEIGHT, 0, 1, 0, 16'sh7FFF);
		push_item(CMD_EVAL, 0, 0, 0, 16'sd0);
		push_item(CMD_WEIGHT, 1, 1023, 63, 16'sh1234);
		push_item(CMD_WEIGHT, 3, 64, 5, 16'sh4321);
		push_item(CMD_BIAS, 3, 1023, 63, 16'sh0100);
		push_item(CMD_FEAT, 3, 1023, 63, 16'sh7FFF);
		push_item(CMD_EVAL, 0, 0, 0, 16'sd0);

		configure(0, 0, 0, 0, 0);
		load_missing();
		random_items(60, 25);

		configure(2, 'h803, 1, 5, 5);
		load_missing();
		random_items(30, 10);

		set_idling(1);
		configure(7, 1, 127, 2, 3);
		load_missing();
		random_items(40, 10);

		for (int p = 0; p < 9; p++) begin
			set_idling(p % 3);
			configure($urandom_range(2, 4), $urandom_range(1, 12), $urandom_range(1, 8),
				$urandom_range(1, 8), $urandom_range(1, 8));
			load_missing();
			if (p == 1) begin
				rx_hold_req = 600;
				random_items(40, 40);
			end
			random_items(60, 20);
			if (p == 2) drain();
			random_items(60, 20);
		end

		set_idling(2);
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && prob_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
